/* src/event_heap_key_update_top_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the event heap key update block
// Short forms for clocked assertions with an asynchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef EVENT_HEAP_KEY_UPDATE_TOP_MACROS_SVH
`define EVENT_HEAP_KEY_UPDATE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EHKU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EHKU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/ehku_pkg.sv */
// ---------------------------------------------------------------------------
// ehku_pkg
// Field widths, mode and register codes and shared types of the event heap.
// ---------------------------------------------------------------------------
package ehku_pkg;

	// Field widths fixed by the item format.
	localparam int MODE_W = 2;
	localparam int ID_W = 10;
	localparam int KEY_W = 32;
	localparam int CFG_W = 11;
	localparam int ITEM_COUNT = 1 << ID_W;

	// Operation codes.
	localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DOWN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UP = 2'd2;
	localparam logic [MODE_W-1:0] MODE_PEEK = 2'd3;

	// Register map: index taken from paddr bit 2.
	localparam logic REG_EIU = 1'b0;
	localparam logic [CFG_W-1:0] EIU_RESET = 11'd1024;

	// Store controls issued by the sequencer.
	typedef struct packed {
		logic place_en;
		logic heap_rd;
		logic pos_rd;
	} store_ctl_t;

endpackage

/* src/ehku_if.sv */
// ---------------------------------------------------------------------------
// ehku_if
// Request and response channels of the event heap, valid/ready handshake.
// ---------------------------------------------------------------------------
interface ehku_req_if;
	import ehku_pkg::*;

	logic valid;
	logic ready;
	logic [MODE_W-1:0] mode;
	logic [ID_W-1:0] item_id;
	logic [KEY_W-1:0] new_key;
	logic [ID_W-1:0] load_position;

	modport source (output valid, mode, item_id, new_key, load_position, input ready);
	modport sink (input valid, mode, item_id, new_key, load_position, output ready);
endinterface

interface ehku_rsp_if;
	import ehku_pkg::*;

	logic valid;
	logic ready;
	logic [ID_W-1:0] top_id;
	logic [KEY_W-1:0] top_key;
	logic [ID_W-1:0] final_position;

	modport source (output valid, top_id, top_key, final_position, input ready);
	modport sink (input valid, top_id, top_key, final_position, output ready);
endinterface

/* src/ehku_store.sv */
// ---------------------------------------------------------------------------
// ehku_store
// Heap id and key memories, the id to position back-map and a root copy.
// ---------------------------------------------------------------------------
module ehku_store #(
	parameter int HEAP_DEPTH = 1024,
	parameter int PW = 10
) (
	input  logic                      clk,
	input  ehku_pkg::store_ctl_t      ctl,
	input  logic [PW-1:0]             place_pos,
	input  logic [ehku_pkg::ID_W-1:0] place_id,
	input  logic [ehku_pkg::KEY_W-1:0] place_key,
	input  logic [PW-1:0]             heap_rd_addr,
	input  logic [ehku_pkg::ID_W-1:0] pos_rd_item,
	output logic [ehku_pkg::ID_W-1:0] rd_id,
	output logic [ehku_pkg::KEY_W-1:0] rd_key,
	output logic [PW-1:0]             rd_pos,
	output logic [ehku_pkg::ID_W-1:0] root_id,
	output logic [ehku_pkg::KEY_W-1:0] root_key
);
	import ehku_pkg::*;

	logic [ID_W-1:0] heap_ids[HEAP_DEPTH];
	logic [KEY_W-1:0] heap_keys[HEAP_DEPTH];
	logic [PW-1:0] pos_of_item[ITEM_COUNT];

	logic [ID_W-1:0] rd_id_q;
	logic [KEY_W-1:0] rd_key_q;
	logic [PW-1:0] rd_pos_q;
	logic [ID_W-1:0] root_id_q;
	logic [KEY_W-1:0] root_key_q;

	// A placement writes the entry and records its position for the id.
	always_ff @(posedge clk) begin
		if (ctl.place_en) begin
			heap_ids[place_pos] <= place_id;
			heap_keys[place_pos] <= place_key;
			pos_of_item[place_id] <= place_pos;
			if (place_pos == '0) begin
				root_id_q <= place_id;
				root_key_q <= place_key;
			end
		end
	end

	// Registered read ports, one on the heap and one on the back-map.
	always_ff @(posedge clk) begin
		if (ctl.heap_rd) begin
			rd_id_q <= heap_ids[heap_rd_addr];
			rd_key_q <= heap_keys[heap_rd_addr];
		end
		if (ctl.pos_rd) begin
			rd_pos_q <= pos_of_item[pos_rd_item];
		end
	end

	assign rd_id = rd_id_q;
	assign rd_key = rd_key_q;
	assign rd_pos = rd_pos_q;
	assign root_id = root_id_q;
	assign root_key = root_key_q;

endmodule

/* src/event_heap_key_update_top.sv */
// ---------------------------------------------------------------------------
// event_heap_key_update_top
// Binary min-heap of item ids keyed by event time, with key update.
// ---------------------------------------------------------------------------
// Requests arrive on req (mode, item_id, new_key, load_position) and each one
// gives exactly one beat on rsp: the root id, the root key and the position
// where the operated item ended up. A load writes one entry in place; a
// sift-down moves the rekeyed item towards the leaves, preferring the left
// child; a sift-up climbs on strictly larger parents but stops at position 1
// or 2. entries_in_use is written over the APB port; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// The block holds one item at a time and a single key comparator serves every
// step. A load first reduces its position below HEAP_DEPTH by repeated
// subtraction; a peek only reads the position of its item; a sift-down
// compares the left and then the right child, where they exist, at each
// level; a sift-up compares the parent at each level. Each level costs one
// registered read of the heap memory per child or parent visited.
// Reset puts the sequencer in idle, empties the result register and sets
// entries_in_use to 1024; heap contents are not cleared and entries must be
// loaded before they are read. A stalled receiver holds the result register;
// the next request is still taken but its result waits for the beat to go.
// ---------------------------------------------------------------------------
module event_heap_key_update_top #(
	parameter int HEAP_DEPTH = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	ehku_req_if.sink   req,
	ehku_rsp_if.source rsp,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);
	import ehku_pkg::*;

	localparam int PW = $clog2(HEAP_DEPTH);
	localparam int CW = PW + 2;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MOD = 4'd1;
	localparam logic [3:0] ST_POS = 4'd2;
	localparam logic [3:0] ST_DN_L = 4'd3;
	localparam logic [3:0] ST_DN_LW = 4'd4;
	localparam logic [3:0] ST_DN_RW = 4'd5;
	localparam logic [3:0] ST_DN_DEC = 4'd6;
	localparam logic [3:0] ST_UP = 4'd7;
	localparam logic [3:0] ST_UP_W = 4'd8;
	localparam logic [3:0] ST_OUT = 4'd9;

	logic [3:0] state_q, state_d;
	logic [CFG_W-1:0] eiu_q;
	logic out_valid_q;

	logic [MODE_W-1:0] mode_q;
	logic [ID_W-1:0] id_q;
	logic [KEY_W-1:0] key_q;
	logic [ID_W-1:0] lpos_q;
	logic [PW-1:0] pos_q;
	logic best_moved_q;
	logic [PW-1:0] best_pos_q;
	logic [ID_W-1:0] best_id_q;
	logic [KEY_W-1:0] best_key_q;
	logic [ID_W-1:0] out_id_q;
	logic [KEY_W-1:0] out_key_q;
	logic [ID_W-1:0] out_pos_q;

	store_ctl_t ctl;
	logic [PW-1:0] place_pos;
	logic [ID_W-1:0] place_id;
	logic [KEY_W-1:0] place_key;
	logic [PW-1:0] heap_rd_addr;
	logic [ID_W-1:0] rd_id;
	logic [KEY_W-1:0] rd_key;
	logic [PW-1:0] rd_pos;
	logic [ID_W-1:0] root_id;
	logic [KEY_W-1:0] root_key;

	logic [CW-1:0] limit_c;
	logic [CW-1:0] left_c;
	logic [CW-1:0] right_c;
	logic [PW-1:0] parent_c;
	logic [KEY_W-1:0] cmp_a, cmp_b;
	logic cmp_lt;
	logic accept;
	logic out_load;
	logic cfg_wr;

	// Heap storage.
	ehku_store #(
		.HEAP_DEPTH(HEAP_DEPTH),
		.PW(PW)
	) u_store (
		.clk(clk),
		.ctl(ctl),
		.place_pos(place_pos),
		.place_id(place_id),
		.place_key(place_key),
		.heap_rd_addr(heap_rd_addr),
		.pos_rd_item(req.item_id),
		.rd_id(rd_id),
		.rd_key(rd_key),
		.rd_pos(rd_pos),
		.root_id(root_id),
		.root_key(root_key)
	);

	// Handshakes and register port.
	assign req.ready = (state_q == ST_IDLE);
	assign accept = req.valid && req.ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || rsp.ready);
	assign rsp.valid = out_valid_q;
	assign rsp.top_id = out_id_q;
	assign rsp.top_key = out_key_q;
	assign rsp.final_position = out_pos_q;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_EIU);
	assign prdata = (paddr[2] == REG_EIU) ? 32'(eiu_q) : '0;

	// Child and parent indices of the current position.
	assign limit_c = (32'(eiu_q) > 32'(HEAP_DEPTH)) ? CW'(HEAP_DEPTH) : CW'(eiu_q);
	assign left_c = CW'({pos_q, 1'b1});
	assign right_c = left_c + CW'(1);
	assign parent_c = PW'((pos_q - PW'(1)) >> 1);

	// The shared key comparator; its operands follow the step in progress.
	always_comb begin
		cmp_a = rd_key;
		cmp_b = key_q;
		unique case (state_q)
			ST_MOD: begin
				cmp_a = KEY_W'(lpos_q);
				cmp_b = KEY_W'(HEAP_DEPTH);
			end
			ST_DN_RW: begin
				cmp_b = best_key_q;
			end
			ST_UP_W: begin
				cmp_a = key_q;
				cmp_b = rd_key;
			end
			default: begin
			end
		endcase
	end
	assign cmp_lt = cmp_a < cmp_b;

	// Sequencer: next state, memory reads and placements.
	always_comb begin
		state_d = state_q;
		ctl = '0;
		place_pos = pos_q;
		place_id = id_q;
		place_key = key_q;
		heap_rd_addr = PW'(left_c);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctl.pos_rd = 1'b1;
					state_d = (req.mode == MODE_LOAD) ? ST_MOD : ST_POS;
				end
			end
			ST_MOD: begin
				if (cmp_lt) begin
					ctl.place_en = 1'b1;
					place_pos = PW'(lpos_q);
					state_d = ST_OUT;
				end
			end
			ST_POS: begin
				unique case (mode_q)
					MODE_DOWN: state_d = ST_DN_L;
					MODE_UP: state_d = ST_UP;
					default: state_d = ST_OUT;
				endcase
			end
			ST_DN_L: begin
				if (left_c < limit_c) begin
					ctl.heap_rd = 1'b1;
					state_d = ST_DN_LW;
				end else begin
					ctl.place_en = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_DN_LW: begin
				if (right_c < limit_c) begin
					ctl.heap_rd = 1'b1;
					heap_rd_addr = PW'(right_c);
					state_d = ST_DN_RW;
				end else begin
					state_d = ST_DN_DEC;
				end
			end
			ST_DN_RW: begin
				ctl.place_en = 1'b1;
				if (cmp_lt) begin
					place_id = rd_id;
					place_key = rd_key;
					state_d = ST_DN_L;
				end else if (best_moved_q) begin
					place_id = best_id_q;
					place_key = best_key_q;
					state_d = ST_DN_L;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DN_DEC: begin
				ctl.place_en = 1'b1;
				if (best_moved_q) begin
					place_id = best_id_q;
					place_key = best_key_q;
					state_d = ST_DN_L;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_UP: begin
				if (pos_q > PW'(2)) begin
					ctl.heap_rd = 1'b1;
					heap_rd_addr = parent_c;
					state_d = ST_UP_W;
				end else begin
					ctl.place_en = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_UP_W: begin
				ctl.place_en = 1'b1;
				if (cmp_lt) begin
					place_id = rd_id;
					place_key = rd_key;
					state_d = ST_UP;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			eiu_q <= EIU_RESET;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				eiu_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	// Item, position and best-child registers; result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			id_q <= req.item_id;
			key_q <= req.new_key;
			lpos_q <= req.load_position;
		end
		case (state_q)
			ST_MOD: begin
				// Reduce the load position below the heap depth.
				if (cmp_lt) begin
					pos_q <= PW'(lpos_q);
				end else begin
					lpos_q <= lpos_q - ID_W'(HEAP_DEPTH);
				end
			end
			ST_POS: begin
				pos_q <= rd_pos;
			end
			ST_DN_LW: begin
				best_moved_q <= cmp_lt;
				best_pos_q <= PW'(left_c);
				best_id_q <= rd_id;
				best_key_q <= cmp_lt ? rd_key : key_q;
			end
			ST_DN_RW: begin
				if (cmp_lt) begin
					pos_q <= PW'(right_c);
				end else if (best_moved_q) begin
					pos_q <= best_pos_q;
				end
			end
			ST_DN_DEC: begin
				if (best_moved_q) begin
					pos_q <= best_pos_q;
				end
			end
			ST_UP_W: begin
				if (cmp_lt) begin
					pos_q <= parent_c;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					out_id_q <= root_id;
					out_key_q <= root_key;
					out_pos_q <= ID_W'(pos_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* src/ehku_checker.sv */
// ---------------------------------------------------------------------------
// ehku_checker
// Port-level checks of the event heap, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "event_heap_key_update_top_macros.svh"

module ehku_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [ehku_pkg::ID_W-1:0]  rsp_top_id,
	input logic [ehku_pkg::KEY_W-1:0] rsp_top_key,
	input logic [ehku_pkg::ID_W-1:0]  rsp_final_position
);
	import ehku_pkg::*;

	// One item at a time: the block is busy in the cycle after a request beat.
	`EHKU_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && req_ready, !req_ready, "request taken while busy")

	// A result appears only at the end of work during which requests were held off.
	`EHKU_ASSERT_SAME(a_result_after_work, clk, arst_n, $rose(rsp_valid), $past(!req_ready), "result without work")

	// A stalled result stays offered.
	`EHKU_ASSERT_NEXT(a_rsp_valid_holds, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

	// A stalled result keeps its payload.
	`EHKU_ASSERT_NEXT(a_rsp_data_holds, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_top_id) && $stable(rsp_top_key) && $stable(rsp_final_position), "result changed while stalled")

endmodule

bind event_heap_key_update_top ehku_checker u_ehku_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_top_id(rsp.top_id),
	.rsp_top_key(rsp.top_key),
	.rsp_final_position(rsp.final_position)
);

/* dv/ehku_heap_checker.sv */
// ---------------------------------------------------------------------------
// ehku_heap_checker
// Watches the request, result and register ports of the event heap. It keeps
// its own copy of the heap, the id-to-position map and entries_in_use, works
// out the result of every accepted request and compares each result beat
// field by field with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module ehku_heap_checker #(
	parameter int HEAP_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	ehku_req_if         req,
	ehku_rsp_if         rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          errors,
	output int          outstanding
);
	import ehku_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0]  top_id;
		logic [KEY_W-1:0] top_key;
		logic [ID_W-1:0]  final_position;
	} heap_result_t;

	// Shadow heap, indexed by position, and the map from id to position.
	logic [ID_W-1:0]  heap_id [HEAP_DEPTH];
	logic [KEY_W-1:0] heap_key [HEAP_DEPTH];
	int               slot_of [ITEM_COUNT];
	int               entries;
	heap_result_t     pending_results [$];

	initial begin
		errors = 0;
		outstanding = 0;
		entries = EIU_RESET;
	end

	// One line per mismatch; after the first fifty they are only counted.
	task automatic report(input string what);
		if (errors < 50) begin
			$display("%0t mismatch: %s", $time, what);
		end
		errors++;
	endtask

	task automatic compare(input string field, input logic [KEY_W-1:0] got,
			input logic [KEY_W-1:0] wanted);
		if (got !== wanted) begin
			report($sformatf("%s is %0h, predicted %0h", field, got, wanted));
		end
	endtask

	function automatic void put_entry(int pos, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
		heap_id[pos] = id;
		heap_key[pos] = key;
		slot_of[id] = pos;
	endfunction

	// Move the rekeyed item towards the leaves. The left child is tried first
	// and a child only wins on a strictly smaller key, so ties stay put.
	function automatic int sink_item(logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
		int limit;
		int pos;
		int best;
		int child;
		logic [KEY_W-1:0] best_key;
		bit settled;
		limit = (entries > HEAP_DEPTH) ? HEAP_DEPTH : entries;
		pos = slot_of[id] % HEAP_DEPTH;
		settled = 1'b0;
		while (!settled) begin
			best = pos;
			best_key = key;
			child = 2 * pos + 1;
			if (child < limit && heap_key[child] < best_key) begin
				best = child;
				best_key = heap_key[child];
			end
			child++;
			if (child < limit && heap_key[child] < best_key) begin
				best = child;
			end
			if (best == pos) begin
				settled = 1'b1;
			end else begin
				put_entry(pos, heap_id[best], heap_key[best]);
				pos = best;
			end
		end
		put_entry(pos, id, key);
		return pos;
	endfunction

	// Move the rekeyed item towards the root on strictly larger parents. It
	// never enters the root: positions 1 and 2 are as high as it goes.
	function automatic int climb_item(logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
		int pos;
		int parent;
		pos = slot_of[id] % HEAP_DEPTH;
		while (pos > 2 && key < heap_key[(pos - 1) / 2]) begin
			parent = (pos - 1) / 2;
			put_entry(pos, heap_id[parent], heap_key[parent]);
			pos = parent;
		end
		put_entry(pos, id, key);
		return pos;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		heap_result_t want;
		int final_pos;
		if (!arst_n) begin
			entries = EIU_RESET;
			pending_results.delete();
			outstanding = 0;
		end else begin
			// A result beat is matched against the oldest prediction.
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					report($sformatf("result beat with top_id %0h and no request waiting",
						rsp.top_id));
				end else begin
					want = pending_results.pop_front();
					compare("top_id", rsp.top_id, want.top_id);
					compare("top_key", rsp.top_key, want.top_key);
					compare("final_position", rsp.final_position, want.final_position);
				end
			end

			// Register write on the access phase.
			if (psel && penable && pwrite && pready && paddr[2] == REG_EIU) begin
				entries = pwdata[CFG_W-1:0];
			end

			// Each accepted request beat yields exactly one predicted result.
			if (req.valid && req.ready) begin
				case (req.mode)
					MODE_LOAD: begin
						final_pos = req.load_position % HEAP_DEPTH;
						put_entry(final_pos, req.item_id, req.new_key);
					end
					MODE_DOWN: final_pos = sink_item(req.item_id, req.new_key);
					MODE_UP:   final_pos = climb_item(req.item_id, req.new_key);
					default:   final_pos = slot_of[req.item_id];
				endcase
				want.top_id = heap_id[0];
				want.top_key = heap_key[0];
				want.final_position = ID_W'(final_pos);
				pending_results.push_back(want);
			end
			outstanding = pending_results.size();
		end
	end

endmodule

/* dv/event_heap_key_update_top_test.sv */
// ---------------------------------------------------------------------------
// event_heap_key_update_top_test
// Drives requests and register writes into the event heap and gives the
// verdict. A short directed sequence on a seven-entry heap comes first, then
// random phases over several entries_in_use settings, including zero, one and
// values at and beyond the depth. Loads grow a fully written prefix of positions so
// that no sift ever reads an entry that was never loaded; the heap is filled
// completely before the largest settings. Both sides idle at random.
// ---------------------------------------------------------------------------
module event_heap_key_update_top_test;
	import ehku_pkg::*;

	localparam int DEPTH = 1024;
	localparam int HOLD_CYCLES = 250;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          outstanding;

	ehku_req_if req ();
	ehku_rsp_if rsp ();

	event_heap_key_update_top #(
		.HEAP_DEPTH(DEPTH)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	ehku_heap_checker #(
		.HEAP_DEPTH(DEPTH)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// Stimulus bookkeeping. Positions below prefix_end have all been loaded;
	// an id is safe to sift only when its last load landed inside that prefix.
	bit               pos_loaded [DEPTH];
	bit               id_sortable [ITEM_COUNT];
	int               sortable_ids [$];
	int               prefix_end;
	logic [CFG_W-1:0] eiu_now;
	bit               steady;
	int               n_load;
	int               n_down;
	int               n_up;
	int               n_peek;
	int               n_settings;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 600000);
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: a random hold-off before each beat, smooth stretches with
	// none, and two long hold-offs that back the block up into its input.
	initial begin : rsp_pacing
		int gap;
		int beats;
		bit smooth;
		rsp.ready <= 1'b0;
		beats = 0;
		smooth = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (beats % 64 == 0) begin
				smooth = ($urandom_range(0, 3) == 0);
			end
			if (beats == 30 || beats == 800) begin
				gap = HOLD_CYCLES;
			end else begin
				gap = smooth ? 0 : $urandom_range(0, 11);
			end
			if (gap != 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			beats++;
		end
	end

	task automatic offer(input logic [MODE_W-1:0] mode, input int id,
			input logic [KEY_W-1:0] key, input int pos);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= mode;
		req.item_id <= ID_W'(id);
		req.new_key <= key;
		req.load_position <= ID_W'(pos);
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic do_load(input int id, input logic [KEY_W-1:0] key, input int pos);
		offer(MODE_LOAD, id, key, pos);
		n_load++;
		pos_loaded[pos] = 1'b1;
		while (prefix_end < DEPTH && pos_loaded[prefix_end]) begin
			prefix_end++;
		end
		if (pos < prefix_end) begin
			if (!id_sortable[id]) begin
				sortable_ids.push_back(id);
			end
			id_sortable[id] = 1'b1;
		end else begin
			id_sortable[id] = 1'b0;
		end
	endtask

	task automatic do_down(input int id, input logic [KEY_W-1:0] key);
		offer(MODE_DOWN, id, key, $urandom_range(0, DEPTH - 1));
		n_down++;
	endtask

	task automatic do_up(input int id, input logic [KEY_W-1:0] key);
		offer(MODE_UP, id, key, $urandom_range(0, DEPTH - 1));
		n_up++;
	endtask

	task automatic do_peek(input int id);
		offer(MODE_PEEK, id, $urandom, $urandom_range(0, DEPTH - 1));
		n_peek++;
	endtask

	// Stop offering and wait until every predicted result has come back.
	task automatic drain();
		req.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic set_entries(input logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_EIU, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		eiu_now = value;
		n_settings++;
	endtask

	// Keys lean towards zero, all ones and a narrow range so that ties occur.
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return KEY_W'($urandom_range(0, 63));
			default: return $urandom;
		endcase
	endfunction

	// Mostly inside the loaded prefix, often extending it, now and then
	// anywhere at all.
	function automatic int pick_pos(input int grow);
		int r;
		r = $urandom_range(0, 99);
		if (prefix_end < DEPTH && r < grow) begin
			return prefix_end;
		end
		if (r < 92) begin
			return $urandom_range(0, prefix_end - 1);
		end
		return $urandom_range(0, DEPTH - 1);
	endfunction

	task automatic random_item(input int grow);
		int r;
		int idx;
		int id;
		int limit;
		logic [KEY_W-1:0] key;
		r = $urandom_range(0, 99);
		key = pick_key();
		limit = (eiu_now > DEPTH) ? DEPTH : eiu_now;
		id = -1;
		if (r >= 30 && sortable_ids.size() != 0) begin
			idx = $urandom_range(0, sortable_ids.size() - 1);
			id = sortable_ids[idx];
			if (!id_sortable[id]) begin
				sortable_ids.delete(idx);
				id = -1;
			end
		end
		// A sift-down may only look at children that have been loaded.
		if (id >= 0 && r >= 94) begin
			do_peek(id);
		end else if (id >= 0 && r >= 62) begin
			do_up(id, key);
		end else if (id >= 0 && limit <= prefix_end) begin
			do_down(id, key);
		end else begin
			if (sortable_ids.size() != 0 && $urandom_range(0, 4) == 0) begin
				id = sortable_ids[$urandom_range(0, sortable_ids.size() - 1)];
			end else begin
				id = $urandom_range(0, ITEM_COUNT - 1);
			end
			do_load(id, key, pick_pos(grow));
		end
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] value, input int count,
			input int grow, input bit quiet);
		drain();
		set_entries(value);
		steady = quiet;
		repeat (count) begin
			random_item(grow);
			if ($urandom_range(0, 59) == 0) begin
				drain();
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req.valid <= 1'b0;
		req.mode <= MODE_LOAD;
		req.item_id <= '0;
		req.new_key <= '0;
		req.load_position <= '0;
		prefix_end = 0;
		steady = 1'b0;
		eiu_now = EIU_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a seven-entry heap with ties between siblings.
		set_entries(11'd7);
		do_load(0, 32'd100, 0);
		do_load(1, 32'd200, 1);
		do_load(2, 32'd50, 2);
		do_load(3, 32'd300, 3);
		do_load(4, 32'd300, 4);
		do_load(5, 32'd60, 5);
		do_load(6, 32'd60, 6);
		// Root pushed to the bottom; the equal siblings leave the left one winning.
		do_down(0, '1);
		// Climbs with a zero key stop short of the root.
		do_up(3, '0);
		do_up(0, '0);
		do_peek(6);
		// An item whose children lie past entries in use is rewritten in place.
		do_down(4, 32'd7);
		// Highest position and id, keys and ids with alternating bits.
		do_load(ITEM_COUNT - 1, '1, DEPTH - 1);
		do_load(10'h2AA, 32'h5555_5555, 7);
		do_load(10'h155, 32'hAAAA_AAAA, 10'h155);
		// Overwrite a slot so that its former item's recorded position is stale.
		do_load(9, 32'd400, 1);
		do_down(3, 32'd1000);
		do_up(2, 32'd10);
		do_down(5, 32'd5);
		do_peek(ITEM_COUNT - 1);

		// Random phases on a small heap, then a full heap at the extremes.
		run_phase(11'd0, 20, 30, 1'b0);
		run_phase(11'd1, 20, 30, 1'b1);
		run_phase(11'd40, 60, 45, 1'b0);
		run_phase(11'd300, 100, 90, 1'b0);

		// Load every remaining position in order, with random ids and keys.
		drain();
		steady = 1'b0;
		while (prefix_end < DEPTH) begin
			do_load($urandom_range(0, ITEM_COUNT - 1), pick_key(), prefix_end);
		end

		run_phase(11'd1024, 60, 0, 1'b0);
		run_phase(11'd2047, 40, 0, 1'b1);
		run_phase(11'd1023, 40, 0, 1'b0);
		run_phase(11'd1, 40, 0, 1'b0);

		drain();
		repeat (40) @(posedge clk);
		$display("Covered %0d requests: %0d loads, %0d sift-downs, %0d sift-ups, %0d peeks.",
			n_load + n_down + n_up + n_peek, n_load, n_down, n_up, n_peek);
		$display("%0d entries_in_use settings from 0 to 2047, heap loaded to %0d positions.",
			n_settings, prefix_end);
		if (errors == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
